### hw/rtl/k_smallest_tracker_defines.svh
// ----------------------------------------------------------------------------
// k_smallest_tracker_defines: assertion macros
// Shared concurrent assertion forms, clocked on clk_i, off during reset.
// ----------------------------------------------------------------------------
`ifndef K_SMALLEST_TRACKER_DEFINES_SVH
`define K_SMALLEST_TRACKER_DEFINES_SVH

// check a property at every clock edge outside reset
`define KST_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error(msg);

// check that a condition implies another one in the next cycle
`define KST_ASSERT_NEXT(label, pre, post, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error(msg);

`endif

### hw/rtl/kst_pkg.sv
// ----------------------------------------------------------------------------
// kst_pkg
// Types and constants shared by the k-smallest tracker chain and control.
// ----------------------------------------------------------------------------
package kst_pkg;

  localparam int DEPTH       = 16;
  localparam int VALUE_BITS  = 32;
  localparam int ROW_BITS    = 8;
  localparam int COLUMN_BITS = 8;
  localparam int KEEP_BITS   = 5;
  localparam int KEEP_RESET  = 16;
  localparam int COUNT_W     = $clog2(DEPTH + 1);
  localparam int IDX_W       = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_REMOVE = 2'd1,
    OP_READ   = 2'd2,
    OP_CLEAR  = 2'd3
  } op_e;

  // per-cycle command broadcast to every cell
  typedef enum logic [1:0] {
    CMD_HOLD,
    CMD_INSERT,
    CMD_REPLACE,
    CMD_REMOVE
  } cmd_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_REMOVE,
    ST_READ
  } state_e;

  typedef struct packed {
    logic signed [VALUE_BITS-1:0]  value;
    logic        [ROW_BITS-1:0]    row;
    logic        [COLUMN_BITS-1:0] column;
  } entry_t;

  typedef struct packed {
    op_e                           opcode;
    logic signed [VALUE_BITS-1:0]  value;
    logic        [ROW_BITS-1:0]    row;
    logic        [COLUMN_BITS-1:0] column;
  } in_word_t;

  typedef struct packed {
    logic signed [VALUE_BITS-1:0]  out_value;
    logic        [ROW_BITS-1:0]    out_row;
    logic        [COLUMN_BITS-1:0] out_column;
    logic                          empty_res;
    logic                          last;
  } out_word_t;

  // cell status handed to its neighbors
  typedef struct packed {
    logic ge;    // held and stored value >= offered value
    logic gt;    // held and stored value >  offered value
    logic kill;  // row match at this cell or any cell to the left
  } cell_stat_t;

endpackage

### hw/rtl/k_smallest_tracker.sv
// ----------------------------------------------------------------------------
// k_smallest_tracker
// Keeps the keep_count smallest values offered, with row and column, in a
// chain of cells sorted largest first; removes rows, reads out, clears.
// ----------------------------------------------------------------------------
//
//   channel   signals                           direction
//   -------   -------------------------------   ---------
//   in        in_valid_i in_ready_o in_word_i   in
//   out       out_valid_o out_ready_i out_word_o out
//   cfg       cfg_we_i cfg_data_i               in
//
// Insert and clear finish in their accept cycle; inserts stream one word per cycle.
// Row removal then holds in_ready_o low until no matching entry is left, as the
// chain drops its first matching cell per cycle. Readout then holds it low until
// the last word (or one empty-result word for an empty list) is loaded, longer
// while the output register stalls; the output register takes the next word only
// when it is empty or its word is being taken.
// Reset clears the fill count, so the list starts empty; keep_count -> 16.
// ----------------------------------------------------------------------------
`include "k_smallest_tracker_defines.svh"

module k_smallest_tracker
  import kst_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  in_word_t             in_word_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output out_word_t            out_word_o,
  input  logic                 cfg_we_i,
  input  logic [KEEP_BITS-1:0] cfg_data_i
);

  state_e                 state_q, state_d;
  logic [COUNT_W-1:0]     count_q, count_d;
  logic [KEEP_BITS-1:0]   keep_q;
  logic [COUNT_W-1:0]     keep_eff;
  logic [IDX_W-1:0]       rd_idx_q, rd_idx_d;
  entry_t                 item_q, item_d;
  logic                   out_valid_q, out_valid_d;
  out_word_t              out_word_q, out_word_d;

  cmd_e                   cmd;
  entry_t                 chain_item;
  entry_t [DEPTH-1:0]     entries;
  logic                   head_gt;
  logic                   any_kill;
  logic                   in_fire;

  // Clamp the configured count to 1..DEPTH.
  always_comb begin
    if (keep_q == '0) begin
      keep_eff = COUNT_W'(1);
    end else if (int'(keep_q) > DEPTH) begin
      keep_eff = COUNT_W'(DEPTH);
    end else begin
      keep_eff = COUNT_W'(keep_q);
    end
  end

  assign in_ready_o = (state_q == ST_IDLE);
  assign in_fire    = in_valid_i && in_ready_o;

  // The chain compares against the incoming word when idle, else the latched row.
  always_comb begin
    if (state_q == ST_IDLE) begin
      chain_item.value  = in_word_i.value;
      chain_item.row    = in_word_i.row;
      chain_item.column = in_word_i.column;
    end else begin
      chain_item = item_q;
    end
  end

  kst_chain u_chain (
    .clk_i      (clk_i),
    .cmd_i      (cmd),
    .item_i     (chain_item),
    .count_i    (count_q),
    .entries_o  (entries),
    .head_gt_o  (head_gt),
    .any_kill_o (any_kill)
  );

  // Sequencer: next state, chain command, output register load.
  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    rd_idx_d    = rd_idx_q;
    item_d      = item_q;
    cmd         = CMD_HOLD;
    out_valid_d = out_valid_q && !out_ready_i;
    out_word_d  = out_word_q;

    unique case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          unique case (in_word_i.opcode)
            OP_INSERT: begin
              if (count_q < keep_eff) begin
                cmd     = CMD_INSERT;
                count_d = count_q + COUNT_W'(1);
              end else if (count_q != '0 && head_gt) begin
                // full: drop the largest, place the new word
                cmd = CMD_REPLACE;
              end
            end
            OP_REMOVE: begin
              item_d  = chain_item;
              state_d = ST_REMOVE;
            end
            OP_READ: begin
              rd_idx_d = '0;
              state_d  = ST_READ;
            end
            OP_CLEAR: begin
              count_d = '0;
            end
            default: begin
              state_d = ST_IDLE;
            end
          endcase
        end
      end
      ST_REMOVE: begin
        // drop the first matching cell each cycle until none is left
        cmd = CMD_REMOVE;
        if (any_kill) begin
          count_d = count_q - COUNT_W'(1);
        end else begin
          state_d = ST_IDLE;
        end
      end
      ST_READ: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d = 1'b1;
          if (count_q == '0) begin
            out_word_d = '{out_value: '0, out_row: '0, out_column: '0,
                           empty_res: 1'b1, last: 1'b1};
            state_d    = ST_IDLE;
          end else begin
            out_word_d.out_value  = entries[rd_idx_q].value;
            out_word_d.out_row    = entries[rd_idx_q].row;
            out_word_d.out_column = entries[rd_idx_q].column;
            out_word_d.empty_res  = 1'b0;
            out_word_d.last       = (rd_idx_q == IDX_W'(count_q - COUNT_W'(1)));
            if (out_word_d.last) begin
              state_d = ST_IDLE;
            end else begin
              rd_idx_d = rd_idx_q + IDX_W'(1);
            end
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= '0;
      rd_idx_q    <= '0;
      out_valid_q <= 1'b0;
      keep_q      <= KEEP_BITS'(KEEP_RESET);
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      rd_idx_q    <= rd_idx_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        keep_q <= cfg_data_i;
      end
    end
  end

  // Payload registers: no reset.
  always_ff @(posedge clk_i) begin
    item_q     <= item_d;
    out_word_q <= out_word_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_word_q;

  `KST_ASSERT(a_count_max, count_q <= COUNT_W'(DEPTH), "fill count above depth")
  `KST_ASSERT_NEXT(a_insert_grows,
    in_fire && in_word_i.opcode == OP_INSERT && count_q < keep_eff,
    count_q == $past(count_q) + COUNT_W'(1), "insert below keep did not grow list")
  `KST_ASSERT_NEXT(a_remove_shrinks, state_q == ST_REMOVE,
    count_q <= $past(count_q), "row removal grew the list")
  `KST_ASSERT(a_empty_last, !(out_valid_o && out_word_o.empty_res) || out_word_o.last,
    "empty readout word without last")

endmodule

### hw/rtl/kst_cell.sv
// ----------------------------------------------------------------------------
// kst_cell
// One slot of the sorted chain: holds an entry, compares it with the offered
// word and takes its next entry from itself, a neighbor or the offered word.
// ----------------------------------------------------------------------------
module kst_cell
  import kst_pkg::*;
(
  input  logic       clk_i,
  input  cmd_e       cmd_i,
  input  entry_t     item_i,
  input  logic       occ_i,
  input  entry_t     left_i,
  input  entry_t     right_i,
  input  logic       left_ge_i,
  input  logic       right_ge_i,
  input  logic       kill_i,
  output entry_t     entry_o,
  output cell_stat_t stat_o
);

  entry_t entry_q, entry_d;

  assign stat_o.ge   = occ_i && (entry_q.value >= item_i.value);
  assign stat_o.gt   = occ_i && (entry_q.value >  item_i.value);
  assign stat_o.kill = kill_i || (occ_i && (entry_q.row == item_i.row));
  assign entry_o     = entry_q;

  always_comb begin
    entry_d = entry_q;
    unique case (cmd_i)
      CMD_INSERT: begin
        // keep larger-or-equal entries, open a slot, push the rest right
        if (stat_o.ge) begin
          entry_d = entry_q;
        end else if (left_ge_i) begin
          entry_d = item_i;
        end else begin
          entry_d = left_i;
        end
      end
      CMD_REPLACE: begin
        // drop the head: pull from the right up to the new slot
        if (right_ge_i) begin
          entry_d = right_i;
        end else if (stat_o.ge) begin
          entry_d = item_i;
        end
      end
      CMD_REMOVE: begin
        if (stat_o.kill) begin
          entry_d = right_i;
        end
      end
      default: begin
        entry_d = entry_q;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

endmodule

### hw/rtl/kst_chain.sv
// ----------------------------------------------------------------------------
// kst_chain
// Row of DEPTH cells, head (largest) at index 0, wired to their neighbors.
// ----------------------------------------------------------------------------
module kst_chain
  import kst_pkg::*;
(
  input  logic                    clk_i,
  input  cmd_e                    cmd_i,
  input  entry_t                  item_i,
  input  logic [COUNT_W-1:0]      count_i,
  output entry_t [DEPTH-1:0]      entries_o,
  output logic                    head_gt_o,
  output logic                    any_kill_o
);

  cell_stat_t stat [DEPTH];

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    entry_t left_e, right_e;
    logic   left_ge, right_ge, kill_in, occ;

    assign occ = (COUNT_W'(i) < count_i);

    if (i == 0) begin : g_first
      assign left_e  = item_i;
      assign left_ge = 1'b1;
      assign kill_in = 1'b0;
    end else begin : g_inner_l
      assign left_e  = entries_o[i-1];
      assign left_ge = stat[i-1].ge;
      assign kill_in = stat[i-1].kill;
    end

    if (i == DEPTH - 1) begin : g_last
      assign right_e  = entries_o[i];
      assign right_ge = 1'b0;
    end else begin : g_inner_r
      assign right_e  = entries_o[i+1];
      assign right_ge = stat[i+1].ge;
    end

    kst_cell u_cell (
      .clk_i      (clk_i),
      .cmd_i      (cmd_i),
      .item_i     (item_i),
      .occ_i      (occ),
      .left_i     (left_e),
      .right_i    (right_e),
      .left_ge_i  (left_ge),
      .right_ge_i (right_ge),
      .kill_i     (kill_in),
      .entry_o    (entries_o[i]),
      .stat_o     (stat[i])
    );
  end

  assign head_gt_o  = stat[0].gt;
  assign any_kill_o = stat[DEPTH-1].kill;

endmodule
